// File: rtl/letter_sum_hash_histogram_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the letter sum hash histogram unit
// Short forms of the concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LETTER_SUM_HASH_HISTOGRAM_UNIT_MACROS_SVH
`define LETTER_SUM_HASH_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsh assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsh assertion failed");

// Next-cycle implication that is checked through reset as well.
`define LSH_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lsh assertion failed");

`endif

// File: rtl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// Constants, codes and shared types of the letter sum hash histogram unit.
// ----------------------------------------------------------------------------
package lsh_pkg;

    // Histogram geometry. The hash word is 9 bits, which fixes 512 bins.
    localparam int NUM_BINS = 512;
    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int SUM_W    = BIN_W + 1;
    localparam int COUNT_W  = 20;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX         = {COUNT_W{1'b1}};
    localparam logic [CHAR_W-1:0]  LETTER_A          = 8'h61;
    localparam int                 LETTER_COUNT      = 26;
    localparam logic [BIN_W-1:0]   FIRST_TRACKED_BIN = BIN_W'(2);

    // Input command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_CHAR   = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REPORT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Result kind codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_WORD   = 2'd0,
        KIND_READ   = 2'd1,
        KIND_REPORT = 2'd2
    } t_kind;

    // Work held between the read issue and the update stage.
    typedef struct packed {
        t_kind                kind;
        logic [BIN_W-1:0]     addr;
        logic                 in_range;
        logic                 out_of_range;
        logic                 fwd_hit;
        logic [COUNT_W-1:0]   fwd_data;
    } t_stage;

    // Bin memory write request.
    typedef struct packed {
        logic                 en;
        logic [BIN_W-1:0]     addr;
        logic [COUNT_W-1:0]   data;
    } t_wr;

    // One result word.
    typedef struct packed {
        t_kind                kind;
        logic [BIN_W-1:0]     hash_bin;
        logic [COUNT_W-1:0]   hit_count;
        logic                 out_of_range;
    } t_result;

endpackage

// File: rtl/lsh_bin_ram.sv
// ----------------------------------------------------------------------------
// lsh_bin_ram
// Histogram bin store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lsh_bin_ram
    import lsh_pkg::*;
(
    input  logic               i_clk,
    input  t_wr                i_wr,
    input  logic               i_rd_en,
    input  logic [BIN_W-1:0]   i_rd_addr,
    output logic [COUNT_W-1:0] o_rd_data
);

    logic [COUNT_W-1:0] r_mem [NUM_BINS];
    logic [COUNT_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/lsh_word_front.sv
// ----------------------------------------------------------------------------
// lsh_word_front
// Word sum accumulator, command decode and bin read issue. Holds the stage
// register that waits for the bin read data.
// ----------------------------------------------------------------------------
module lsh_word_front
    import lsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic               i_end_of_word,
    input  logic [BIN_W-1:0]   i_bin_index,
    input  logic               i_s1_fire,
    input  t_wr                i_wr,
    output logic               o_rd_en,
    output logic [BIN_W-1:0]   o_rd_addr,
    output logic               o_s1_valid,
    output t_stage             o_s1
);

    localparam int ADD_W = SUM_W + 1;

    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic              r_s1_valid;
    logic              n_s1_valid;
    t_stage            r_s1;
    t_stage            n_s1;

    logic              is_letter;
    logic [4:0]        letter_val;
    logic [ADD_W-1:0]  sum_raw;
    logic [SUM_W-1:0]  sum_sat;
    logic              req_valid;
    logic              req_rd;
    t_stage            req;

    // Letter value 1..26, other bytes add nothing.
    always_comb begin
        is_letter  = (i_char_code >= LETTER_A) &&
                     (i_char_code < CHAR_W'(LETTER_A + CHAR_W'(LETTER_COUNT)));
        letter_val = is_letter ? (5'(i_char_code - LETTER_A) + 5'd1) : 5'd0;
        sum_raw    = {1'b0, r_sum} + ADD_W'(letter_val);
        sum_sat    = (sum_raw >= ADD_W'(NUM_BINS)) ? SUM_W'(NUM_BINS)
                                                   : sum_raw[SUM_W-1:0];
    end

    // Command decode into the stage request.
    always_comb begin
        req_valid        = 1'b0;
        req_rd           = 1'b0;
        n_sum            = r_sum;
        req.kind         = KIND_WORD;
        req.addr         = '0;
        req.in_range     = 1'b0;
        req.out_of_range = 1'b0;
        case (t_cmd'(i_cmd))
            CMD_CHAR: begin
                n_sum = i_end_of_word ? '0 : sum_sat;
                if (i_end_of_word) begin
                    req_valid        = 1'b1;
                    req.kind         = KIND_WORD;
                    req.addr         = sum_sat[BIN_W-1:0];
                    req.in_range     = (sum_sat < SUM_W'(NUM_BINS));
                    req.out_of_range = !req.in_range;
                    req_rd           = req.in_range;
                end
            end
            CMD_READ: begin
                req_valid    = 1'b1;
                req.kind     = KIND_READ;
                req.addr     = i_bin_index;
                req.in_range = ({1'b0, i_bin_index} < SUM_W'(NUM_BINS));
                req_rd       = req.in_range;
            end
            CMD_REPORT: begin
                req_valid = 1'b1;
                req.kind  = KIND_REPORT;
            end
            default: begin
                req_valid = 1'b0;
            end
        endcase
        // A write landing on the same edge as the read is not seen by the
        // read, so it is captured here for forwarding.
        req.fwd_hit  = i_wr.en && (i_wr.addr == req.addr);
        req.fwd_data = i_wr.data;
    end

    // Stage register next values.
    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;
        if (i_accept) begin
            n_s1_valid = req_valid;
            n_s1       = req;
        end else if (i_s1_fire) begin
            n_s1_valid = 1'b0;
        end
    end

    // Word sum and stage state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_sum <= n_sum;
            end
            r_s1_valid <= n_s1_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_rd_en    = i_accept && req_rd;
    assign o_rd_addr  = req.addr;
    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

// File: rtl/lsh_bin_update.sv
// ----------------------------------------------------------------------------
// lsh_bin_update
// Bin count increment with saturation, write back, and the running maximum
// over bins of index 2 and above.
// ----------------------------------------------------------------------------
module lsh_bin_update
    import lsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stage             i_s1,
    input  logic               i_s1_fire,
    input  logic [COUNT_W-1:0] i_rd_data,
    output t_wr                o_wr,
    output t_result            o_res
);

    logic [BIN_W-1:0]   r_best_index;
    logic [COUNT_W-1:0] r_best_count;

    logic [COUNT_W-1:0] base;
    logic [COUNT_W-1:0] incr;
    logic               do_write;
    logic               take_best;

    // Current count with forwarding, and its saturating increment.
    always_comb begin
        base      = i_s1.fwd_hit ? i_s1.fwd_data : i_rd_data;
        incr      = (base == COUNT_MAX) ? base : (base + COUNT_W'(1));
        do_write  = i_s1_fire && (i_s1.kind == KIND_WORD) && i_s1.in_range;
        take_best = do_write && (i_s1.addr >= FIRST_TRACKED_BIN) &&
                    ((incr > r_best_count) ||
                     ((incr == r_best_count) && (i_s1.addr < r_best_index)));
    end

    // Write back request.
    assign o_wr.en   = do_write;
    assign o_wr.addr = i_s1.addr;
    assign o_wr.data = incr;

    // Result word.
    always_comb begin
        o_res.kind         = i_s1.kind;
        o_res.hash_bin     = '0;
        o_res.hit_count    = '0;
        o_res.out_of_range = 1'b0;
        case (i_s1.kind)
            KIND_WORD: begin
                o_res.out_of_range = i_s1.out_of_range;
                if (i_s1.in_range) begin
                    o_res.hash_bin  = i_s1.addr;
                    o_res.hit_count = incr;
                end
            end
            KIND_READ: begin
                o_res.hash_bin  = i_s1.addr;
                o_res.hit_count = i_s1.in_range ? base : '0;
            end
            KIND_REPORT: begin
                o_res.hash_bin  = r_best_index;
                o_res.hit_count = r_best_count;
            end
            default: begin
                o_res.kind = KIND_WORD;
            end
        endcase
    end

    // Running maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_index <= '0;
            r_best_count <= '0;
        end else if (take_best) begin
            r_best_index <= i_s1.addr;
            r_best_count <= incr;
        end
    end

endmodule

// File: rtl/letter_sum_hash_histogram_unit.sv
// ----------------------------------------------------------------------------
// letter_sum_hash_histogram_unit
// Letter sum word hash with a 512 bin collision histogram held in one RAM.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) takes one word per accepted edge: a
// character (with end of word mark), a bin read, or a maximum report.
// Output channel (o_valid / i_ready) gives one result word per end of word,
// bin read or report; mid-word characters and unused commands give none.
// A result passes the stage register and then the output register: the
// accepting edge issues the bin RAM read, and when the stage advances it
// increments, writes back and loads the output register.
// Throughput is one input word per cycle while the receiver keeps up; a bin
// updated by one word and read by the next is forwarded around the RAM, so
// no bubble is needed. After reset a clearing pass writes zero to all 512
// bins, one per cycle; o_ready stays low until the pass has finished.
// When the receiver stalls, the result holds in the output register and one
// more word can sit in the update stage; o_ready then drops until i_ready
// frees the output register.
// ----------------------------------------------------------------------------
module letter_sum_hash_histogram_unit
    import lsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic               i_end_of_word,
    input  logic [BIN_W-1:0]   i_bin_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [KIND_W-1:0]  o_kind,
    output logic [BIN_W-1:0]   o_hash_bin,
    output logic [COUNT_W-1:0] o_hit_count,
    output logic               o_out_of_range
);

    logic [BIN_W-1:0]   r_clr_addr;
    logic               r_clr_done;
    logic               r_out_valid;
    t_result            r_out;

    logic               accept;
    logic               s1_valid;
    logic               s1_adv;
    logic               s1_fire;
    t_stage             s1;
    logic               rd_en;
    logic [BIN_W-1:0]   rd_addr;
    logic [COUNT_W-1:0] rd_data;
    t_wr                upd_wr;
    t_wr                ram_wr;
    t_result            res;

    // Handshake and stage advance.
    assign s1_adv  = !r_out_valid || i_ready;
    assign s1_fire = s1_valid && s1_adv;
    assign o_ready = r_clr_done && (!s1_valid || s1_adv);
    assign accept  = i_valid && o_ready;

    // The clearing pass owns the write port until it finishes.
    always_comb begin
        if (!r_clr_done) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = r_clr_addr;
            ram_wr.data = '0;
        end else begin
            ram_wr = upd_wr;
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            r_clr_addr <= r_clr_addr + BIN_W'(1);
            r_clr_done <= (r_clr_addr == BIN_W'(NUM_BINS - 1));
        end
    end

    lsh_word_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_char_code   (i_char_code),
        .i_end_of_word (i_end_of_word),
        .i_bin_index   (i_bin_index),
        .i_s1_fire     (s1_fire),
        .i_wr          (ram_wr),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_s1_valid    (s1_valid),
        .o_s1          (s1)
    );

    lsh_bin_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lsh_bin_update u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_s1_fire (s1_fire),
        .i_rd_data (rd_data),
        .o_wr      (upd_wr),
        .o_res     (res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_hash_bin     = r_out.hash_bin;
    assign o_hit_count    = r_out.hit_count;
    assign o_out_of_range = r_out.out_of_range;

endmodule

// File: rtl/lsh_checker.sv
// ----------------------------------------------------------------------------
// lsh_checker
// Port level checks of the letter sum hash histogram unit, bound to the top.
// ----------------------------------------------------------------------------
`include "letter_sum_hash_histogram_unit_macros.svh"

module lsh_checker
    import lsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [KIND_W-1:0]  o_kind,
    input  logic [BIN_W-1:0]   o_hash_bin,
    input  logic [COUNT_W-1:0] o_hit_count,
    input  logic               o_out_of_range
);

    // A stalled result stays put.
    `LSH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_kind) && $stable(o_hash_bin) && $stable(o_hit_count))

    // An uncounted word reports hash and count zero.
    `LSH_ASSERT_IMP(a_oor_word, i_clk, i_rst_n, o_valid && o_out_of_range,
        (o_kind == KIND_WORD) && (o_hash_bin == '0) && (o_hit_count == '0))

    // The clearing pass blocks input right after reset.
    `LSH_ASSERT_NXT_ALWAYS(a_clear_blocks, i_clk, !i_rst_n, !o_ready)

    // The maximum never names bin 0 or 1 with a nonzero count.
    `LSH_ASSERT_IMP(a_report_low_bin, i_clk, i_rst_n,
        o_valid && (o_kind == KIND_REPORT) && (o_hash_bin < FIRST_TRACKED_BIN),
        o_hit_count == '0)

endmodule

bind letter_sum_hash_histogram_unit lsh_checker u_lsh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_kind         (o_kind),
    .o_hash_bin     (o_hash_bin),
    .o_hit_count    (o_hit_count),
    .o_out_of_range (o_out_of_range)
);

// File: test/lsh_checker.sv
// ----------------------------------------------------------------------------
// lsh_tb_checker
// Watches both channels of the letter sum hash histogram unit, keeps its own
// copy of the word sum, the bins and the running maximum, predicts the result
// of every accepted input word that gives one and compares each accepted
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module lsh_tb_checker
    import lsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic               i_end_of_word,
    input  logic [BIN_W-1:0]   i_bin_index,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [BIN_W-1:0]   i_hash_bin,
    input  logic [COUNT_W-1:0] i_hit_count,
    input  logic               i_out_of_range,
    output int                 o_fail_count,
    output int                 o_pending
);

    // Shadow state of the histogram.
    int                 word_total;
    logic [COUNT_W-1:0] bin_count [NUM_BINS];
    int                 lead_bin;
    logic [COUNT_W-1:0] lead_count;

    // Results predicted but not yet seen on the output channel.
    t_result            hist_results [$];
    int                 fails = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("lsh_checker: %s mismatch, got %0d, want %0d", what, got, want);
        fails++;
    endtask

    // Applies one accepted input word to the shadow state and queues its result.
    task automatic hash_and_count();
        t_result            res;
        int                 key;
        logic [COUNT_W-1:0] cnt;
        res = '0;
        case (t_cmd'(i_cmd))
            CMD_CHAR: begin
                // Only lowercase letters add to the sum, which stops at NUM_BINS.
                if (int'(i_char_code) >= int'(LETTER_A) &&
                    int'(i_char_code) < int'(LETTER_A) + LETTER_COUNT) begin
                    word_total += int'(i_char_code) - int'(LETTER_A) + 1;
                    if (word_total > NUM_BINS) begin
                        word_total = NUM_BINS;
                    end
                end
                if (i_end_of_word) begin
                    key        = word_total;
                    word_total = 0;
                    res.kind   = KIND_WORD;
                    if (key >= NUM_BINS) begin
                        res.out_of_range = 1'b1;
                    end else begin
                        // Saturating bin update and incremental maximum.
                        cnt = bin_count[key];
                        if (cnt != COUNT_MAX) begin
                            cnt = cnt + COUNT_W'(1);
                        end
                        bin_count[key] = cnt;
                        if (key >= int'(FIRST_TRACKED_BIN) &&
                            (cnt > lead_count || (cnt == lead_count && key < lead_bin))) begin
                            lead_count = cnt;
                            lead_bin   = key;
                        end
                        res.hash_bin  = BIN_W'(key);
                        res.hit_count = cnt;
                    end
                    hist_results.push_back(res);
                end
            end
            CMD_READ: begin
                res.kind      = KIND_READ;
                res.hash_bin  = i_bin_index;
                res.hit_count = bin_count[i_bin_index];
                hist_results.push_back(res);
            end
            CMD_REPORT: begin
                res.kind      = KIND_REPORT;
                res.hash_bin  = BIN_W'(lead_bin);
                res.hit_count = lead_count;
                hist_results.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    // Compares one accepted result word with the oldest prediction.
    task automatic compare_result();
        t_result want;
        if (hist_results.size() == 0) begin
            report_mismatch("unexpected result, kind", i_kind, -1);
        end else begin
            want = hist_results.pop_front();
            if (i_kind !== want.kind) begin
                report_mismatch("kind", i_kind, want.kind);
            end
            if (i_hash_bin !== want.hash_bin) begin
                report_mismatch("hash_bin", i_hash_bin, want.hash_bin);
            end
            if (i_hit_count !== want.hit_count) begin
                report_mismatch("hit_count", i_hit_count, want.hit_count);
            end
            if (i_out_of_range !== want.out_of_range) begin
                report_mismatch("out_of_range", i_out_of_range, want.out_of_range);
            end
        end
    endtask

    // A result leaves only after its input has passed the stage and output
    // registers, so the output side is handled before the input side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_total = 0;
            lead_bin   = 0;
            lead_count = '0;
            hist_results.delete();
            for (int b = 0; b < NUM_BINS; b++) begin
                bin_count[b] = '0;
            end
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_result();
            end
            if (i_in_valid && i_in_ready) begin
                hash_and_count();
            end
        end
        o_fail_count <= fails;
        o_pending    <= hist_results.size();
    end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the letter sum hash histogram unit. A directed
// opening covers empty words, untracked bins, ties, non-letters, unused
// commands and the report before any hit; random words, long words near the
// bin limit, reads, reports and noise follow, with random gaps on both sides,
// one long receiver hold-off and one drain pause. The checker beside the
// block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import lsh_pkg::*;

    localparam int ITEM_TARGET = 1965;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [CMD_W-1:0]   i_cmd;
    logic [CHAR_W-1:0]  i_char_code;
    logic               i_end_of_word;
    logic [BIN_W-1:0]   i_bin_index;
    logic               o_valid;
    logic               i_ready;
    logic [KIND_W-1:0]  o_kind;
    logic [BIN_W-1:0]   o_hash_bin;
    logic [COUNT_W-1:0] o_hit_count;
    logic               o_out_of_range;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit burst_mode  = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    bit drain_done  = 1'b0;

    letter_sum_hash_histogram_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_end_of_word  (i_end_of_word),
        .i_bin_index    (i_bin_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_hash_bin     (o_hash_bin),
        .o_hit_count    (o_hit_count),
        .o_out_of_range (o_out_of_range)
    );

    lsh_tb_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_end_of_word  (i_end_of_word),
        .i_bin_index    (i_bin_index),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_kind         (o_kind),
        .i_hash_bin     (o_hash_bin),
        .i_hit_count    (o_hit_count),
        .i_out_of_range (o_out_of_range),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Offers one input word, waits for it to be taken, then maybe idles.
    task automatic put_word(input t_cmd cmd, input logic [CHAR_W-1:0] ch, input logic eow,
                            input logic [BIN_W-1:0] idx);
        int pick;
        int gap;
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_char_code   <= ch;
        i_end_of_word <= eow;
        i_bin_index   <= idx;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        if (cmd != CMD_NONE) begin
            items_sent++;
        end
        if (!burst_mode) begin
            pick = $urandom_range(0, 99);
            gap  = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // A short word of random letters with an occasional stray byte.
    task automatic send_short_word();
        int                n;
        logic [CHAR_W-1:0] ch;
        n = $urandom_range(0, 8);
        if (n == 0) begin
            // A lone random byte carrying the end mark: an empty word unless the byte is a letter.
            put_word(CMD_CHAR, CHAR_W'($urandom), 1'b1, BIN_W'($urandom));
        end else begin
            for (int k = 0; k < n; k++) begin
                ch = ($urandom_range(0, 9) == 0) ? CHAR_W'($urandom)
                                                 : CHAR_W'(LETTER_A + $urandom_range(0, 25));
                put_word(CMD_CHAR, ch, (k == n - 1), BIN_W'($urandom));
            end
        end
    endtask

    // A word whose sum lands near or past the last bin, saturating beyond it.
    task automatic send_long_word();
        int left;
        left = $urandom_range(500, 560);
        while (left > LETTER_COUNT) begin
            put_word(CMD_CHAR, CHAR_W'(LETTER_A + LETTER_COUNT - 1), 1'b0, BIN_W'($urandom));
            left -= LETTER_COUNT;
        end
        put_word(CMD_CHAR, CHAR_W'(LETTER_A + left - 1), 1'b1, BIN_W'($urandom));
    endtask

    // Stimulus.
    initial begin
        int pick;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cmd         <= CMD_CHAR;
        i_char_code   <= '0;
        i_end_of_word <= 1'b0;
        i_bin_index   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening.
        put_word(CMD_REPORT, 8'h00, 1'b0, '0);             // report before any hit
        put_word(CMD_READ,   8'hFF, 1'b1, '0);
        put_word(CMD_READ,   8'h00, 1'b0, '1);
        put_word(CMD_CHAR,   8'h20, 1'b1, '0);             // empty word into bin 0
        put_word(CMD_CHAR,   8'hFF, 1'b1, '1);             // another empty word
        put_word(CMD_CHAR,   8'h61, 1'b1, '0);             // bin 1, not tracked
        put_word(CMD_REPORT, 8'h00, 1'b0, '0);
        put_word(CMD_CHAR,   8'h7A, 1'b1, '0);             // bin 26
        put_word(CMD_CHAR,   8'h62, 1'b1, '0);             // bin 2, ties with 26
        put_word(CMD_REPORT, 8'h00, 1'b0, '0);
        put_word(CMD_CHAR,   8'h60, 1'b0, '0);             // bytes just outside a..z
        put_word(CMD_CHAR,   8'h7B, 1'b0, '0);
        put_word(CMD_CHAR,   8'h80, 1'b0, '0);
        put_word(CMD_CHAR,   8'h7A, 1'b1, '0);             // bin 26 again, new leader
        put_word(CMD_NONE,   8'h61, 1'b1, '1);             // unused command
        put_word(CMD_READ,   8'h00, 1'b0, BIN_W'(26));
        put_word(CMD_READ,   8'h00, 1'b0, BIN_W'(2));
        put_word(CMD_REPORT, 8'h00, 1'b0, '0);
        put_word(CMD_CHAR,   8'h00, 1'b0, '0);
        put_word(CMD_CHAR,   8'h61, 1'b1, '0);             // word "\0a" into bin 1

        // Random part.
        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= 600) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= 1300) begin
                // Drain pause: nothing offered until every result has come.
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                repeat (TAIL_CYCLES) @(posedge i_clk);
                drain_done = 1'b1;
            end
            burst_mode = (items_sent >= 900 && items_sent < 1100);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_short_word();
            end else if (pick < 58) begin
                send_long_word();
            end else if (pick < 72) begin
                put_word(CMD_READ, CHAR_W'($urandom), 1'($urandom),
                         $urandom_range(0, 1) ? BIN_W'($urandom_range(0, 60)) : BIN_W'($urandom));
            end else if (pick < 84) begin
                put_word(CMD_REPORT, CHAR_W'($urandom), 1'($urandom), BIN_W'($urandom));
            end else begin
                put_word(t_cmd'($urandom_range(0, 3)), CHAR_W'($urandom), 1'($urandom),
                         BIN_W'($urandom));
            end
        end

        // Let every result come out, idle for TAIL_CYCLES, then give the verdict.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Receiver: random ready pattern, plus one long hold-off on request.
    initial begin
        int run;
        i_ready <= 1'b0;
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                repeat (run) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/lsh_pkg.sv
rtl/lsh_bin_ram.sv
rtl/lsh_word_front.sv
rtl/lsh_bin_update.sv
rtl/letter_sum_hash_histogram_unit.sv
rtl/lsh_checker.sv
test/lsh_checker.sv
test/tb.sv
